@@ design/sjfs_pkg.sv @@
// Shared types and constants for the shortest-job-first scheduler.
package sjfs_pkg;

   // Default capacity of one task set.
   localparam int MAX_TASKS_DEFAULT = 64;
   // Default depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   // Width of the enqueue and processing time fields.
   localparam int FIELD_WIDTH = 32;
   // Width of the task index output field.
   localparam int INDEX_WIDTH = 6;

   // One classified task as it travels from the front part to the back part.
   typedef struct packed {
      logic [FIELD_WIDTH-1:0] enqueue_time;
      logic [FIELD_WIDTH-1:0] processing_time;
      logic                   last_task;
      logic                   store;
      logic                   overflow;
   } task_entry_type;

   // Back part sequencer states.
   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SCAN,
      BACK_DONE
   } back_state_type;

   // Status of the back part, watched by checks at the top level.
   typedef struct packed {
      logic emit;
      logic pick_ok;
      logic sel_in_range;
      logic last_emit;
      logic idle;
   } back_status_type;

endpackage

@@ design/sjfs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module sjfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sjfs_queue.sv @@
// Short FIFO of classified tasks between the front and back parts.
module sjfs_queue #(
   parameter int DEPTH = sjfs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  sjfs_pkg::task_entry_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output sjfs_pkg::task_entry_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   sjfs_pkg::task_entry_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          do_push, do_pop;

   assign push_ready = (fill_ff != CW'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill level updates; pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CW'(1);
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/sjfs_front.sv @@
// Front part: accepts task transactions and classifies them against capacity.
module sjfs_front #(
   parameter int MAX_TASKS = sjfs_pkg::MAX_TASKS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sjfs_pkg::FIELD_WIDTH-1:0]    req_enqueue_time,
   input  logic [sjfs_pkg::FIELD_WIDTH-1:0]    req_processing_time,
   input  logic                                req_last_task,
   output logic                                push_valid,
   input  logic                                push_ready,
   output sjfs_pkg::task_entry_type            push_data
);

   localparam int CW = $clog2(MAX_TASKS + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic          accept;
   logic          store;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;
   assign store      = (count_ff != CW'(MAX_TASKS));

   // Classified entry: whether it fits, and the set's drop flag so far.
   always_comb begin
      push_data.enqueue_time    = req_enqueue_time;
      push_data.processing_time = req_processing_time;
      push_data.last_task       = req_last_task;
      push_data.store           = store;
      push_data.overflow        = dropped_ff || !store;
   end

   // Set bookkeeping; the last task of a set starts a fresh count.
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (accept) begin
         if (req_last_task) begin
            count_in   = '0;
            dropped_in = 1'b0;
         end else if (store) begin
            count_in = count_ff + CW'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

endmodule

@@ design/sjfs_back.sv @@
// Back part: stores tasks of a set, then schedules them by repeated scans.
module sjfs_back #(
   parameter int MAX_TASKS = sjfs_pkg::MAX_TASKS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  sjfs_pkg::task_entry_type            pop_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sjfs_pkg::INDEX_WIDTH-1:0]    rsp_task_index,
   output logic                                rsp_last_result,
   output logic                                rsp_overflow,
   output sjfs_pkg::back_status_type           status
);

   localparam int FW = sjfs_pkg::FIELD_WIDTH;
   localparam int OW = sjfs_pkg::INDEX_WIDTH;
   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int TW = FW + CW;

   sjfs_pkg::back_state_type state_ff, state_in;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] k_ff, k_in;
   logic [TW-1:0] time_ff, time_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] pidx_ff, pidx_in;
   logic          found_ff, found_in;
   logic [FW-1:0] bdur_ff, bdur_in;
   logic [IW-1:0] bidx_ff, bidx_in;
   logic          mval_ff, mval_in;
   logic [FW-1:0] amin_ff, amin_in;
   logic [FW-1:0] mdur_ff, mdur_in;
   logic [IW-1:0] midx_ff, midx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0] rsp_idx_ff, rsp_idx_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic            task_we, fin_we, fin_wdata;
   logic [IW-1:0]   wr_addr, rd_addr;
   logic [2*FW-1:0] task_wdata, task_rdata;
   logic            fin_rdata;
   logic [FW-1:0]   rd_arr, rd_dur;
   logic            emit, is_last;
   logic [IW-1:0]   sel;
   logic [IW+OW-1:0] sel_wide;
   logic [TW-1:0]   base_time;
   logic [FW-1:0]   sel_dur;

   // Arrival and duration of each stored task.
   sjfs_ram #(.WIDTH(2 * FW), .DEPTH(MAX_TASKS)) u_task_ram (
      .clock   (clock),
      .wr_en   (task_we),
      .wr_addr (wr_addr),
      .wr_data (task_wdata),
      .rd_addr (rd_addr),
      .rd_data (task_rdata)
   );

   // Finished flag of each stored task, cleared as the task is loaded.
   sjfs_ram #(.WIDTH(1), .DEPTH(MAX_TASKS)) u_fin_ram (
      .clock   (clock),
      .wr_en   (fin_we),
      .wr_addr (wr_addr),
      .wr_data (fin_wdata),
      .rd_addr (rd_addr),
      .rd_data (fin_rdata)
   );

   assign rd_arr     = task_rdata[2*FW-1:FW];
   assign rd_dur     = task_rdata[FW-1:0];
   assign rd_addr    = issue_ff[IW-1:0];
   assign task_wdata = {pop_data.enqueue_time, pop_data.processing_time};

   // Choice at the end of a scan: an available task, else the earliest group.
   assign sel       = found_ff ? bidx_ff : midx_ff;
   assign sel_dur   = found_ff ? bdur_ff : mdur_ff;
   assign base_time = found_ff ? time_ff : TW'(amin_ff);
   assign sel_wide  = {{OW{1'b0}}, sel};
   assign is_last   = (({1'b0, k_ff} + (CW + 1)'(1)) == {1'b0, cnt_ff});
   assign emit      = (state_ff == sjfs_pkg::BACK_DONE) && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = (state_ff == sjfs_pkg::BACK_IDLE);

   // Sequencer: load, scan all stored tasks, then emit one pick per scan.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      time_in      = time_ff;
      ovf_in       = ovf_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pidx_in      = issue_ff[IW-1:0];
      found_in     = found_ff;
      bdur_in      = bdur_ff;
      bidx_in      = bidx_ff;
      mval_in      = mval_ff;
      amin_in      = amin_ff;
      mdur_in      = mdur_ff;
      midx_in      = midx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      task_we      = 1'b0;
      fin_we       = 1'b0;
      fin_wdata    = 1'b0;
      wr_addr      = cnt_ff[IW-1:0];
      case (state_ff)
         sjfs_pkg::BACK_IDLE: begin
            if (pop_valid) begin
               if (pop_data.store) begin
                  task_we = 1'b1;
                  fin_we  = 1'b1;
                  cnt_in  = cnt_ff + CW'(1);
               end
               if (pop_data.last_task) begin
                  ovf_in   = pop_data.overflow;
                  issue_in = '0;
                  found_in = 1'b0;
                  mval_in  = 1'b0;
                  state_in = sjfs_pkg::BACK_SCAN;
               end
            end
         end
         sjfs_pkg::BACK_SCAN: begin
            // Issue one read a cycle; judge the entry read in the cycle before.
            if (issue_ff != cnt_ff) begin
               issue_in = issue_ff + CW'(1);
               pend_in  = 1'b1;
            end else if (!pend_ff) begin
               state_in = sjfs_pkg::BACK_DONE;
            end
            if (pend_ff && !fin_rdata) begin
               if ((TW'(rd_arr) <= time_ff) && (!found_ff || (rd_dur < bdur_ff))) begin
                  found_in = 1'b1;
                  bdur_in  = rd_dur;
                  bidx_in  = pidx_ff;
               end
               if (!mval_ff || (rd_arr < amin_ff) ||
                   ((rd_arr == amin_ff) && (rd_dur < mdur_ff))) begin
                  mval_in = 1'b1;
                  amin_in = rd_arr;
                  mdur_in = rd_dur;
                  midx_in = pidx_ff;
               end
            end
         end
         sjfs_pkg::BACK_DONE: begin
            if (emit) begin
               fin_we       = 1'b1;
               fin_wdata    = 1'b1;
               wr_addr      = sel;
               rsp_valid_in = 1'b1;
               rsp_idx_in   = sel_wide[OW-1:0];
               rsp_last_in  = is_last;
               rsp_ovf_in   = ovf_ff;
               issue_in     = '0;
               found_in     = 1'b0;
               mval_in      = 1'b0;
               if (is_last) begin
                  cnt_in   = '0;
                  k_in     = '0;
                  time_in  = '0;
                  ovf_in   = 1'b0;
                  state_in = sjfs_pkg::BACK_IDLE;
               end else begin
                  k_in     = k_ff + CW'(1);
                  time_in  = base_time + TW'(sel_dur);
                  state_in = sjfs_pkg::BACK_SCAN;
               end
            end
         end
         default: begin
            state_in = sjfs_pkg::BACK_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sjfs_pkg::BACK_IDLE;
         cnt_ff       <= '0;
         k_ff         <= '0;
         time_ff      <= '0;
         ovf_ff       <= 1'b0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         mval_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         time_ff      <= time_in;
         ovf_ff       <= ovf_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         mval_ff      <= mval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Scan candidates and result payload.
   always_ff @(posedge clock) begin
      pidx_ff     <= pidx_in;
      bdur_ff     <= bdur_in;
      bidx_ff     <= bidx_in;
      amin_ff     <= amin_in;
      mdur_ff     <= mdur_in;
      midx_ff     <= midx_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_task_index  = rsp_idx_ff;
   assign rsp_last_result = rsp_last_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   always_comb begin
      status.emit         = emit;
      status.pick_ok      = found_ff || mval_ff;
      status.sel_in_range = ({1'b0, sel} < (IW + 1)'(cnt_ff));
      status.last_emit    = is_last;
      status.idle         = (state_ff == sjfs_pkg::BACK_IDLE);
   end

endmodule

@@ design/shortest_job_first_scheduler_core.sv @@
// Top level of the non-preemptive shortest-job-first scheduler.
//
// Tasks arrive one per transaction on the req_ channel and are accepted one per cycle, while
// the queue has room, into a short queue; while loading, the back part stores one queued task
// per cycle in its task memory. The task flagged last closes the set; the block then emits
// one rsp_ transaction per stored task in execution order, starting at time 0, choosing the
// available task with the shortest processing time and the lower index on ties, and jumping
// time forward when none is available. Each result takes one full pass over the N stored
// tasks through the memory read port, then the read latency, the final judgment and the emit.
// While a set is being scheduled, req_ready falls once the queue is full. Tasks beyond
// MAX_TASKS in a set are dropped, and every result of that set shows rsp_overflow.
// The task memory needs no clearing after reset.
module shortest_job_first_scheduler_core #(
   parameter int MAX_TASKS   = sjfs_pkg::MAX_TASKS_DEFAULT,
   parameter int QUEUE_DEPTH = sjfs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sjfs_pkg::FIELD_WIDTH-1:0]    req_enqueue_time,
   input  logic [sjfs_pkg::FIELD_WIDTH-1:0]    req_processing_time,
   input  logic                                req_last_task,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sjfs_pkg::INDEX_WIDTH-1:0]    rsp_task_index,
   output logic                                rsp_last_result,
   output logic                                rsp_overflow
);

   logic                      push_valid, push_ready;
   logic                      pop_valid, pop_ready;
   sjfs_pkg::task_entry_type  push_data, pop_data;
   sjfs_pkg::back_status_type back_status;

   // Accept and classify incoming tasks.
   sjfs_front #(.MAX_TASKS(MAX_TASKS)) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_enqueue_time    (req_enqueue_time),
      .req_processing_time (req_processing_time),
      .req_last_task       (req_last_task),
      .push_valid          (push_valid),
      .push_ready          (push_ready),
      .push_data           (push_data)
   );

   // Decouple the front from the back.
   sjfs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Store the set and schedule it.
   sjfs_back #(.MAX_TASKS(MAX_TASKS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_task_index  (rsp_task_index),
      .rsp_last_result (rsp_last_result),
      .rsp_overflow    (rsp_overflow),
      .status          (back_status)
   );

   // Every emitted pick comes from a scan that found an unfinished task.
   assert property (@(posedge clock) disable iff (reset)
      back_status.emit |-> back_status.pick_ok)
      else $error("scheduler emitted a result without a candidate task");

   // The picked index always lies within the stored set.
   assert property (@(posedge clock) disable iff (reset)
      back_status.emit |-> back_status.sel_in_range)
      else $error("scheduler picked a task outside the stored set");

   // Emitting the final task of a set returns the back part to loading.
   assert property (@(posedge clock) disable iff (reset)
      (back_status.emit && back_status.last_emit) |=> back_status.idle)
      else $error("scheduler did not return to loading after the final result");

endmodule
